>>> hdl/spcp_pkg.sv
// Shared types, constants and codes of the serial pulse command parser.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package spcp_pkg;

  // Line buffer geometry.
  localparam int LineBytes  = 16;
  localparam int StoreDepth = LineBytes - 1;
  localparam int LenW       = $clog2(LineBytes);
  localparam int StIdxW     = $clog2(StoreDepth);

  // Field widths.
  localparam int ByteW   = 8;
  localparam int PulseW  = 12;
  localparam int KindW   = 3;
  localparam int CfgIdxW = 2;
  localparam int CandW   = PulseW + 1;

  // Decimal parser: magnitudes saturate at MagCap.
  localparam int             MagW   = 17;
  localparam logic [MagW-1:0] MagCap = 17'd100000;
  localparam int             PctW   = 7;
  localparam int             PctMax = 100;
  localparam int             StopLen = 4;

  // Command queue between front and back.
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // Register reset values.
  localparam logic [PulseW-1:0] MinReset   = 12'd1000;
  localparam logic [PulseW-1:0] MaxReset   = 12'd2000;
  localparam logic [PulseW-1:0] StopReset  = 12'd1000;
  // Stop width clamped into the reset range.
  localparam logic [PulseW-1:0] PulseReset = 12'd1000;

  // Character codes.
  localparam logic [ByteW-1:0] ChBs    = 8'h08;
  localparam logic [ByteW-1:0] ChTab   = 8'h09;
  localparam logic [ByteW-1:0] ChLf    = 8'h0A;
  localparam logic [ByteW-1:0] ChCr    = 8'h0D;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChPlus  = 8'h2B;
  localparam logic [ByteW-1:0] ChMinus = 8'h2D;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;
  localparam logic [ByteW-1:0] ChPUp   = 8'h50;
  localparam logic [ByteW-1:0] ChO     = 8'h6F;
  localparam logic [ByteW-1:0] ChP     = 8'h70;
  localparam logic [ByteW-1:0] ChS     = 8'h73;
  localparam logic [ByteW-1:0] ChT     = 8'h74;
  localparam logic [ByteW-1:0] ChDel   = 8'h7F;

  typedef enum logic [KindW-1:0] {
    EV_ECHO    = 3'd0,
    EV_ERASE   = 3'd1,
    EV_PROMPT  = 3'd2,
    EV_PULSE   = 3'd3,
    EV_INVALID = 3'd4
  } event_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN  = 2'd0,
    CFG_MAX  = 2'd1,
    CFG_STOP = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_CHAR  = 2'd0,
    CMD_ERASE = 2'd1,
    CMD_EOL   = 2'd2
  } cmd_kind_e;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_WALK  = 2'd1,
    BK_CALC  = 2'd2,
    BK_CLAMP = 2'd3
  } back_state_e;

  typedef enum logic [1:0] {
    PS_WS   = 2'd0,
    PS_DIG  = 2'd1,
    PS_DONE = 2'd2
  } parse_phase_e;

  typedef struct packed {
    cmd_kind_e             kind;
    logic [ByteW-1:0]      data;
  } cmd_t;

  typedef struct packed {
    logic [PulseW-1:0] min_pulse;
    logic [PulseW-1:0] max_pulse;
    logic [PulseW-1:0] stop_pulse;
  } cfg_t;

endpackage

`default_nettype wire

>>> hdl/serial_pulse_command_parser.sv
// Serial pulse command parser: top level with configuration registers.
// Depends on spcp_pkg, spcp_front, spcp_queue and spcp_back.
// An accepted byte is written into the queue and then taken by the back end
// into the result register once that register is free. A line end walks the
// line buffer one character per cycle, up to the effective line length (at
// most 15), then, unless the line is blank, passes the calc and clamp states.
// Reset (rst_ni low, asynchronous) empties the line, the queue and the result
// register and loads min 1000, max 2000, stop 1000 and pulse width 1000.
`default_nettype none

module serial_pulse_command_parser (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Received bytes. tdata: rx_byte[7:0].
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [7:0]                     s_axis_tdata,
  // Results. tdata: echo_char[7:0], pulse_us[19:8], zero[23:20].
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [23:0]                         m_axis_tdata,
  // tuser: event_kind[2:0].
  output logic [2:0]                          m_axis_tuser,
  // Configuration writes; index 0 min, 1 max, 2 stop, 3 ignored.
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [spcp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [spcp_pkg::PulseW-1:0]    cfg_data_i
);

  // The front end only classifies each item as character, erase or line end;
  // the back end owns the line buffer and all evaluation. The queue between
  // them lets the serial side deliver up to two bytes while a line is evaluated.

  spcp_pkg::cfg_t                    cfg_q;
  logic                              q_full;
  logic                              q_push;
  logic                              q_valid;
  logic                              q_pop;
  spcp_pkg::cmd_t                    q_in;
  spcp_pkg::cmd_t                    q_out;
  spcp_pkg::event_kind_e             out_kind;
  logic [spcp_pkg::ByteW-1:0]        out_echo;
  logic [spcp_pkg::PulseW-1:0]       out_pulse;

  // Registers are always writable; the user must change them only while the
  // block is idle; the block does not enforce it. Writes never touch pulse_q.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_pulse  <= spcp_pkg::MinReset;
      cfg_q.max_pulse  <= spcp_pkg::MaxReset;
      cfg_q.stop_pulse <= spcp_pkg::StopReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        spcp_pkg::CFG_MIN:  cfg_q.min_pulse  <= cfg_data_i;
        spcp_pkg::CFG_MAX:  cfg_q.max_pulse  <= cfg_data_i;
        spcp_pkg::CFG_STOP: cfg_q.stop_pulse <= cfg_data_i;
        default:            cfg_q            <= cfg_q;
      endcase
    end
  end

  spcp_front u_front (
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .full_i     (q_full),
    .push_o     (q_push),
    .entry_o    (q_in)
  );

  spcp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .entry_o (q_out)
  );

  spcp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_pop),
    .cmd_i       (q_out),
    .cfg_i       (cfg_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (out_kind),
    .out_echo_o  (out_echo),
    .out_pulse_o (out_pulse)
  );

  assign m_axis_tdata = {4'b0000, out_pulse, out_echo};
  assign m_axis_tuser = out_kind;

endmodule

`default_nettype wire

>>> hdl/spcp_front.sv
// Front end: accepts received bytes and classifies them into commands.
// Depends on spcp_pkg.
`default_nettype none

module spcp_front (
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [spcp_pkg::ByteW-1:0] in_byte_i,
  input  wire logic                       full_i,
  output logic                            push_o,
  output spcp_pkg::cmd_t                  entry_o
);

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    entry_o.data = in_byte_i;
    if (in_byte_i inside {spcp_pkg::ChCr, spcp_pkg::ChLf}) begin
      entry_o.kind = spcp_pkg::CMD_EOL;
    end else if (in_byte_i inside {spcp_pkg::ChBs, spcp_pkg::ChDel}) begin
      entry_o.kind = spcp_pkg::CMD_ERASE;
    end else begin
      entry_o.kind = spcp_pkg::CMD_CHAR;
    end
  end

endmodule

`default_nettype wire

>>> hdl/spcp_queue.sv
// Short command queue that decouples the front end from the back end.
// Depends on spcp_pkg.
`default_nettype none

module spcp_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  spcp_pkg::cmd_t      entry_i,
  output logic                full_o,
  output logic                valid_o,
  input  wire logic           pop_i,
  output spcp_pkg::cmd_t      entry_o
);

  spcp_pkg::cmd_t                  mem_q [spcp_pkg::QueueDepth];
  logic [spcp_pkg::QPtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [spcp_pkg::QPtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [spcp_pkg::QCntW-1:0]      cnt_q, cnt_d;
  logic                            do_pop;

  assign full_o  = (cnt_q == spcp_pkg::QCntW'(spcp_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign do_pop  = pop_i && valid_o;
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == spcp_pkg::QPtrW'(spcp_pkg::QueueDepth - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == spcp_pkg::QPtrW'(spcp_pkg::QueueDepth - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

>>> hdl/spcp_back.sv
// Back end: line buffer, character-serial line evaluation and result register.
// Depends on spcp_pkg.
`default_nettype none

module spcp_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cmd_valid_i,
  output logic                               cmd_ready_o,
  input  spcp_pkg::cmd_t                     cmd_i,
  input  spcp_pkg::cfg_t                     cfg_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output spcp_pkg::event_kind_e              out_kind_o,
  output logic [spcp_pkg::ByteW-1:0]         out_echo_o,
  output logic [spcp_pkg::PulseW-1:0]        out_pulse_o
);

  localparam int MagAccW = spcp_pkg::MagW + 4;

  spcp_pkg::back_state_e               state_q, state_d;
  logic [spcp_pkg::LenW-1:0]           len_q, len_d;
  logic [spcp_pkg::LenW-1:0]           idx_q, idx_d;
  logic                                lead_q, lead_d;
  logic                                stop_q, stop_d;
  logic [2:0]                          k_q, k_d;
  logic                                pmode_q, pmode_d;
  spcp_pkg::parse_phase_e              ps_phase_q, ps_phase_d, ps_phase_nx;
  logic [spcp_pkg::MagW-1:0]           ps_mag_q, ps_mag_d, ps_mag_nx;
  logic                                ps_neg_q, ps_neg_d, ps_neg_nx;
  logic                                ok_q, ok_d;
  logic [spcp_pkg::CandW-1:0]          cand_q, cand_d;
  logic [spcp_pkg::PulseW-1:0]         pulse_q, pulse_d;
  logic                                out_valid_q, out_valid_d;
  spcp_pkg::event_kind_e               out_kind_q, out_kind_d;
  logic [spcp_pkg::ByteW-1:0]          out_echo_q, out_echo_d;
  logic [spcp_pkg::PulseW-1:0]         out_pulse_q, out_pulse_d;

  logic [spcp_pkg::ByteW-1:0]          store_q [spcp_pkg::StoreDepth];
  logic                                st_we;

  logic                                pop;
  logic [spcp_pkg::ByteW-1:0]          cur_c;
  logic                                at_end;
  logic                                is_digit;
  logic [MagAccW-1:0]                  mag_acc;
  logic                                neg_bad;
  logic                                pct_ok;
  logic                                bare_ok;
  logic [spcp_pkg::CandW-1:0]          pct_val;
  logic [spcp_pkg::PulseW-1:0]         clamped;
  logic [spcp_pkg::ByteW-1:0]          stop_exp;

  assign cmd_ready_o = (state_q == spcp_pkg::BK_IDLE) && (!out_valid_q || out_ready_i);
  assign pop         = cmd_ready_o && cmd_valid_i;

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_echo_o  = out_echo_q;
  assign out_pulse_o = out_pulse_q;

  // Current character of the walk; past the stored length it reads as zero,
  // and a zero byte ends the line.
  assign cur_c    = (idx_q < len_q) ? store_q[idx_q[spcp_pkg::StIdxW-1:0]] : '0;
  assign at_end   = (cur_c == '0);
  assign is_digit = (cur_c inside {[spcp_pkg::ChZero:spcp_pkg::ChNine]});
  assign mag_acc  = (MagAccW'(ps_mag_q) << 3) + (MagAccW'(ps_mag_q) << 1) +
                    MagAccW'(cur_c[3:0]);

  // One step of the decimal parser on the current character.
  always_comb begin
    ps_phase_nx = ps_phase_q;
    ps_mag_nx   = ps_mag_q;
    ps_neg_nx   = ps_neg_q;
    case (ps_phase_q)
      spcp_pkg::PS_WS: begin
        if (cur_c == spcp_pkg::ChSpace ||
            cur_c inside {[spcp_pkg::ChTab:spcp_pkg::ChCr]}) begin
          ps_phase_nx = spcp_pkg::PS_WS;
        end else if (cur_c inside {spcp_pkg::ChPlus, spcp_pkg::ChMinus}) begin
          ps_neg_nx   = (cur_c == spcp_pkg::ChMinus);
          ps_phase_nx = spcp_pkg::PS_DIG;
        end else if (is_digit) begin
          ps_mag_nx   = spcp_pkg::MagW'(cur_c[3:0]);
          ps_phase_nx = spcp_pkg::PS_DIG;
        end else begin
          ps_phase_nx = spcp_pkg::PS_DONE;
        end
      end
      spcp_pkg::PS_DIG: begin
        if (is_digit) begin
          ps_mag_nx = (mag_acc > MagAccW'(spcp_pkg::MagCap)) ?
                      spcp_pkg::MagCap : mag_acc[spcp_pkg::MagW-1:0];
        end else begin
          ps_phase_nx = spcp_pkg::PS_DONE;
        end
      end
      default: begin
        ps_phase_nx = ps_phase_q;
      end
    endcase
  end

  always_comb begin
    case (k_q)
      3'd1:    stop_exp = spcp_pkg::ChT;
      3'd2:    stop_exp = spcp_pkg::ChO;
      3'd3:    stop_exp = spcp_pkg::ChP;
      default: stop_exp = '0;
    endcase
  end

  // Range checks on the parsed value.
  assign neg_bad = ps_neg_q && (ps_mag_q != '0);
  assign pct_ok  = !neg_bad && (ps_mag_q <= spcp_pkg::MagW'(spcp_pkg::PctMax));
  assign bare_ok = !neg_bad &&
                   (ps_mag_q >= spcp_pkg::MagW'(cfg_i.min_pulse)) &&
                   (ps_mag_q <= spcp_pkg::MagW'(cfg_i.max_pulse));
  assign pct_val = spcp_pkg::CandW'(cfg_i.min_pulse) +
                   spcp_pkg::CandW'(ps_mag_q[spcp_pkg::PctW-1:0]) *
                   spcp_pkg::CandW'(10);

  always_comb begin
    if (cand_q < spcp_pkg::CandW'(cfg_i.min_pulse)) begin
      clamped = cfg_i.min_pulse;
    end else if (cand_q > spcp_pkg::CandW'(cfg_i.max_pulse)) begin
      clamped = cfg_i.max_pulse;
    end else begin
      clamped = cand_q[spcp_pkg::PulseW-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      spcp_pkg::BK_IDLE: begin
        if (pop && cmd_i.kind == spcp_pkg::CMD_EOL) begin
          state_d = spcp_pkg::BK_WALK;
        end
      end
      spcp_pkg::BK_WALK: begin
        if (at_end) begin
          state_d = lead_q ? spcp_pkg::BK_IDLE : spcp_pkg::BK_CALC;
        end
      end
      spcp_pkg::BK_CALC: begin
        state_d = spcp_pkg::BK_CLAMP;
      end
      spcp_pkg::BK_CLAMP: begin
        state_d = spcp_pkg::BK_IDLE;
      end
      default: begin
        state_d = spcp_pkg::BK_IDLE;
      end
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    len_d       = len_q;
    idx_d       = idx_q;
    lead_d      = lead_q;
    stop_d      = stop_q;
    k_d         = k_q;
    pmode_d     = pmode_q;
    ps_phase_d  = ps_phase_q;
    ps_mag_d    = ps_mag_q;
    ps_neg_d    = ps_neg_q;
    ok_d        = ok_q;
    cand_d      = cand_q;
    pulse_d     = pulse_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_kind_d  = out_kind_q;
    out_echo_d  = out_echo_q;
    out_pulse_d = out_pulse_q;
    st_we       = 1'b0;
    case (state_q)
      spcp_pkg::BK_IDLE: begin
        if (pop) begin
          case (cmd_i.kind)
            spcp_pkg::CMD_CHAR: begin
              if (len_q < spcp_pkg::LenW'(spcp_pkg::StoreDepth)) begin
                st_we       = 1'b1;
                len_d       = len_q + 1'b1;
                out_valid_d = 1'b1;
                out_kind_d  = spcp_pkg::EV_ECHO;
                out_echo_d  = cmd_i.data;
                out_pulse_d = pulse_q;
              end
            end
            spcp_pkg::CMD_ERASE: begin
              if (len_q != '0) begin
                len_d       = len_q - 1'b1;
                out_valid_d = 1'b1;
                out_kind_d  = spcp_pkg::EV_ERASE;
                out_echo_d  = '0;
                out_pulse_d = pulse_q;
              end
            end
            spcp_pkg::CMD_EOL: begin
              idx_d      = '0;
              lead_d     = 1'b1;
              stop_d     = 1'b0;
              k_d        = '0;
              pmode_d    = 1'b0;
              ps_phase_d = spcp_pkg::PS_WS;
              ps_mag_d   = '0;
              ps_neg_d   = 1'b0;
            end
            default: begin
              len_d = len_q;
            end
          endcase
        end
      end
      spcp_pkg::BK_WALK: begin
        idx_d = idx_q + 1'b1;
        if (lead_q) begin
          if (at_end) begin
            out_valid_d = 1'b1;
            out_kind_d  = spcp_pkg::EV_PROMPT;
            out_echo_d  = '0;
            out_pulse_d = pulse_q;
            len_d       = '0;
          end else if (!(cur_c inside {spcp_pkg::ChSpace, spcp_pkg::ChTab})) begin
            lead_d  = 1'b0;
            stop_d  = (cur_c == spcp_pkg::ChS);
            k_d     = 3'd1;
            pmode_d = (cur_c inside {spcp_pkg::ChP, spcp_pkg::ChPUp});
            if (!(cur_c inside {spcp_pkg::ChP, spcp_pkg::ChPUp})) begin
              ps_phase_d = ps_phase_nx;
              ps_mag_d   = ps_mag_nx;
              ps_neg_d   = ps_neg_nx;
            end
          end
        end else begin
          if (k_q < 3'(spcp_pkg::StopLen)) begin
            stop_d = stop_q && (cur_c == stop_exp);
            k_d    = k_q + 1'b1;
          end else begin
            stop_d = stop_q && at_end;
          end
          ps_phase_d = ps_phase_nx;
          ps_mag_d   = ps_mag_nx;
          ps_neg_d   = ps_neg_nx;
        end
      end
      spcp_pkg::BK_CALC: begin
        if (stop_q) begin
          ok_d   = 1'b1;
          cand_d = spcp_pkg::CandW'(cfg_i.stop_pulse);
        end else if (pmode_q) begin
          ok_d   = pct_ok;
          cand_d = pct_val;
        end else begin
          ok_d   = bare_ok;
          cand_d = ps_mag_q[spcp_pkg::CandW-1:0];
        end
      end
      spcp_pkg::BK_CLAMP: begin
        len_d       = '0;
        out_valid_d = 1'b1;
        out_echo_d  = '0;
        if (ok_q) begin
          pulse_d     = clamped;
          out_kind_d  = spcp_pkg::EV_PULSE;
          out_pulse_d = clamped;
        end else begin
          out_kind_d  = spcp_pkg::EV_INVALID;
          out_pulse_d = pulse_q;
        end
      end
      default: begin
        out_valid_d = out_valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spcp_pkg::BK_IDLE;
      len_q       <= '0;
      pulse_q     <= spcp_pkg::PulseReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      pulse_q     <= pulse_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    lead_q      <= lead_d;
    stop_q      <= stop_d;
    k_q         <= k_d;
    pmode_q     <= pmode_d;
    ps_phase_q  <= ps_phase_d;
    ps_mag_q    <= ps_mag_d;
    ps_neg_q    <= ps_neg_d;
    ok_q        <= ok_d;
    cand_q      <= cand_d;
    out_kind_q  <= out_kind_d;
    out_echo_q  <= out_echo_d;
    out_pulse_q <= out_pulse_d;
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      store_q[len_q[spcp_pkg::StIdxW-1:0]] <= cmd_i.data;
    end
  end

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= spcp_pkg::LenW'(spcp_pkg::StoreDepth))
    else $error("line length beyond buffer depth");

  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != spcp_pkg::BK_IDLE |-> !out_valid_q)
    else $error("result register busy during line evaluation");

  a_walk_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == spcp_pkg::BK_WALK |-> idx_q <= len_q)
    else $error("walk index ran past the line");

  a_clamp_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == spcp_pkg::BK_CLAMP |=>
      out_valid_q && (out_kind_q == spcp_pkg::EV_PULSE ||
                      out_kind_q == spcp_pkg::EV_INVALID))
    else $error("line evaluation gave no command result");

endmodule

`default_nettype wire

>>> tb/serial_pulse_command_parser_tb.sv
// Self-checking testbench for the serial pulse command parser.
// Drives bytes and register writes, predicts every result item and compares it.
// Depends on spcp_pkg and the serial_pulse_command_parser RTL only.
`timescale 1ns / 1ps

module serial_pulse_command_parser_tb;
  import spcp_pkg::*;

  localparam int  ClkHalf     = 6;
  localparam int  CycleLimit  = 1000000;
  // A line end walks up to 15 characters, then the calc and clamp states; this
  // is comfortably longer than anything the block can still have in flight.
  localparam int  SettleCycles = 40;
  localparam int  HoldCycles   = 400;
  localparam int  PhaseItems   = 400;
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  // One result item as the block presents it.
  typedef struct packed {
    event_kind_e       kind;
    logic [ByteW-1:0]  echo;
    logic [PulseW-1:0] pulse;
  } line_result_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [23:0]         m_axis_tdata;
  logic [2:0]          m_axis_tuser;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [PulseW-1:0]   cfg_data_i    = '0;

  serial_pulse_command_parser uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #ClkHalf clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the line buffer, the commanded width and
  // the three registers. It is updated the moment the block accepts an item.
  // ---------------------------------------------------------------------------
  logic [ByteW-1:0]  line_buf [StoreDepth];
  int                line_len  = 0;
  logic [PulseW-1:0] pulse_now = PulseReset;
  logic [PulseW-1:0] min_reg   = MinReset;
  logic [PulseW-1:0] max_reg   = MaxReset;
  logic [PulseW-1:0] stop_reg  = StopReset;

  line_result_t pending_results[$];
  int           error_count   = 0;
  int           result_count  = 0;
  int           burst_left    = 0;
  int           hold_seq      = 0;
  int           cycle_count   = 0;

  function automatic logic [ByteW-1:0] line_char(input int i, input int len);
    return (i < len) ? line_buf[i] : 8'h00;
  endfunction

  function automatic logic [PulseW-1:0] clamp_pulse(input int v);
    if (v < int'(min_reg)) return min_reg;
    if (v > int'(max_reg)) return max_reg;
    return v[PulseW-1:0];
  endfunction

  // Decimal conversion in the manner of strtol: leading white space, an
  // optional sign, digits up to the first non-digit. The magnitude saturates
  // so that long digit strings can never wrap back into range.
  function automatic int parse_decimal(input int start, input int len);
    int               pos;
    int               mag;
    bit               neg;
    logic [ByteW-1:0] c;
    pos = start;
    mag = 0;
    neg = 1'b0;
    c   = line_char(pos, len);
    while (c == ChSpace || (c >= ChTab && c <= ChCr)) begin
      pos++;
      c = line_char(pos, len);
    end
    if (c == ChPlus || c == ChMinus) begin
      neg = (c == ChMinus);
      pos++;
      c = line_char(pos, len);
    end
    while (c >= ChZero && c <= ChNine) begin
      mag = mag * 10 + int'(c - ChZero);
      if (mag > int'(MagCap)) mag = int'(MagCap);
      pos++;
      c = line_char(pos, len);
    end
    return neg ? -mag : mag;
  endfunction

  // Applies one accepted byte to the predictor. Returns 1 when the byte makes
  // the block emit a result item, and fills in what that item must hold.
  function automatic bit predict_byte(input logic [ByteW-1:0] b, output line_result_t r);
    int               len;
    int               s;
    int               v;
    logic [ByteW-1:0] c0;
    r.kind  = EV_ECHO;
    r.echo  = '0;
    r.pulse = pulse_now;
    if (b == ChCr || b == ChLf) begin
      // The line ends early at a stored zero byte.
      len = 0;
      while (len < line_len && line_buf[len] != 8'h00) len++;
      s = 0;
      while (s < len && (line_buf[s] == ChSpace || line_buf[s] == ChTab)) s++;
      if (s >= len) begin
        r.kind = EV_PROMPT;
      end else begin
        c0 = line_buf[s];
        if (len - s == StopLen && c0 == ChS && line_char(s + 1, len) == ChT &&
            line_char(s + 2, len) == ChO && line_char(s + 3, len) == ChP) begin
          pulse_now = clamp_pulse(int'(stop_reg));
          r.kind    = EV_PULSE;
        end else if (c0 == ChP || c0 == ChPUp) begin
          v = parse_decimal(s + 1, len);
          if (v >= 0 && v <= PctMax) begin
            pulse_now = clamp_pulse(int'(min_reg) + 10 * v);
            r.kind    = EV_PULSE;
          end else begin
            r.kind = EV_INVALID;
          end
        end else begin
          v = parse_decimal(s, len);
          if (v >= int'(min_reg) && v <= int'(max_reg)) begin
            pulse_now = clamp_pulse(v);
            r.kind    = EV_PULSE;
          end else begin
            r.kind = EV_INVALID;
          end
        end
      end
      line_len = 0;
    end else if (b == ChBs || b == ChDel) begin
      if (line_len == 0) return 1'b0;
      line_len--;
      r.kind = EV_ERASE;
    end else begin
      // A full line silently drops every further ordinary byte.
      if (line_len >= StoreDepth) return 1'b0;
      line_buf[line_len] = b;
      line_len++;
      r.echo = b;
    end
    r.pulse = pulse_now;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Byte sender. Items go out in bursts of random length separated by random
  // gaps; some bursts follow each other with no gap at all. tvalid stays high
  // from one item to the next inside a burst, so it gets one assignment per
  // clock edge at most.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [ByteW-1:0] b);
    int           gap;
    line_result_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    if (predict_byte(b, r)) begin
      pending_results.push_back(r);
      result_count++;
    end
  endtask

  task automatic send_text(input string text);
    for (int i = 0; i < text.len(); i++) send_byte(text[i]);
  endtask

  // Registers may only change while the block is idle: every expected item has
  // arrived and the block has had time to finish bytes that produce no item.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes min, max and stop back to back, optionally followed by a write to
  // the unused index, which the block must ignore.
  task automatic configure(input logic [PulseW-1:0] min_v, input logic [PulseW-1:0] max_v,
                           input logic [PulseW-1:0] stop_v, input bit hit_unused);
    logic [CfgIdxW-1:0] idx   [4];
    logic [PulseW-1:0]  value [4];
    int                 count;
    idx[0] = CFG_MIN;   value[0] = min_v;
    idx[1] = CFG_MAX;   value[1] = max_v;
    idx[2] = CFG_STOP;  value[2] = stop_v;
    idx[3] = CfgUnused; value[3] = PulseW'($urandom);
    count  = hit_unused ? 4 : 3;
    wait_idle();
    for (int k = 0; k < count; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i  <= value[k];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx[k])
        CFG_MIN:  min_reg  = value[k];
        CFG_MAX:  max_reg  = value[k];
        CFG_STOP: stop_reg = value[k];
        default:  ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver. Per stall window it picks a new stall rate, from never stalling to
  // almost always stalling. A test can also request a long hold-off, which this
  // process counts out on its own while the sender keeps offering items.
  // ---------------------------------------------------------------------------
  int stall_pct    = 0;
  int stall_window = 0;
  int hold_left    = 0;
  int hold_seen    = 0;

  always @(posedge clk_i) begin
    if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = HoldCycles;
    end
    if (stall_window == 0) begin
      stall_window = 50;
      case ($urandom_range(0, 4))
        0, 1:    stall_pct = 0;
        2:       stall_pct = 30;
        3:       stall_pct = 70;
        default: stall_pct = 95;
      endcase
    end
    stall_window--;
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker. Each accepted result item is compared field by field with
  // the oldest expectation; an item with nothing waiting is a failure too.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    line_result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d data %h",
                 $time, m_axis_tuser, m_axis_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.kind) begin
          $display("%0t: event kind mismatch, expected %0d, actual %0d",
                   $time, want.kind, m_axis_tuser);
          error_count++;
        end
        if (m_axis_tdata[7:0] !== want.echo) begin
          $display("%0t: echo char mismatch, expected %h, actual %h",
                   $time, want.echo, m_axis_tdata[7:0]);
          error_count++;
        end
        if (m_axis_tdata[19:8] !== want.pulse) begin
          $display("%0t: pulse width mismatch, expected %0d, actual %0d",
                   $time, want.pulse, m_axis_tdata[19:8]);
          error_count++;
        end
        if (m_axis_tdata[23:20] !== 4'h0) begin
          $display("%0t: padding bits mismatch, expected 0, actual %h",
                   $time, m_axis_tdata[23:20]);
          error_count++;
        end
      end
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Echo, erase by DEL, erase by backspace on an empty line (no item), and an
  // empty line giving a prompt.
  task automatic test_line_editing();
    send_byte("q");
    send_byte(ChDel);
    send_byte(ChBs);
    send_byte(ChCr);
  endtask

  // A bare decimal in range, cut short by a stored zero byte, padded out to a
  // full line with 0xFF, one byte dropped on the full line, then LF.
  task automatic test_full_line();
    send_text("1500");
    send_byte(8'h00);
    repeat (StoreDepth - 5) send_byte(8'hFF);
    send_byte("A");
    send_byte(ChLf);
  endtask

  // Register extremes with min above max: clamping yields min, a negative
  // percent is rejected, and the unused register index is ignored.
  task automatic test_min_above_max();
    configure(12'hFFF, 12'h000, 12'h000, 1'b1);
    send_text("stop");
    send_byte(ChCr);
    send_text("p-1");
    send_byte(ChCr);
  endtask

  // The receiver holds off for a long stretch while the sender streams
  // echo/erase pairs back to back, so the block fills up and stalls its input.
  task automatic test_backpressure();
    wait_idle();
    hold_seq++;
    burst_left = 1000;
    for (int i = 0; i < 20; i++) begin
      send_byte("a");
      send_byte(ChBs);
    end
    burst_left = 0;
  endtask

  task automatic send_number(input int v, input bit signed_form);
    string digits;
    if (signed_form || v < 0) send_byte((v < 0) ? ChMinus : ChPlus);
    digits = $sformatf("%0d", (v < 0) ? -v : v);
    send_text(digits);
  endtask

  // One random line. Most are commands with random content, some malformed; the
  // rest are empty lines and raw noise, all with occasional edits.
  task automatic send_random_line();
    int lo;
    int hi;
    int v;
    int choice;
    repeat ($urandom_range(0, 2)) send_byte(($urandom_range(0, 1) != 0) ? ChSpace : ChTab);
    if ($urandom_range(0, 5) == 0) begin
      send_byte(ByteW'($urandom));
      send_byte(($urandom_range(0, 1) != 0) ? ChBs : ChDel);
    end
    choice = $urandom_range(0, 9);
    case (choice)
      0, 1, 2: begin
        // Bare decimal, usually within the accepted window.
        lo = int'(min_reg);
        hi = int'(max_reg);
        if (lo <= hi && $urandom_range(0, 3) != 0) v = $urandom_range(lo, hi);
        else if ($urandom_range(0, 4) == 0) v = $urandom_range(0, 99999999);
        else v = $urandom_range(0, 4095);
        if ($urandom_range(0, 7) == 0) v = -v;
        send_number(v, $urandom_range(0, 7) == 0);
      end
      3, 4: begin
        send_byte(($urandom_range(0, 1) != 0) ? ChP : ChPUp);
        if ($urandom_range(0, 5) == 0) send_byte(ChSpace);
        v = ($urandom_range(0, 4) != 0) ? $urandom_range(0, PctMax) : $urandom_range(0, 1000);
        if ($urandom_range(0, 9) == 0) v = -v;
        send_number(v, $urandom_range(0, 7) == 0);
        if ($urandom_range(0, 5) == 0) send_byte("x");
      end
      5: begin
        case ($urandom_range(0, 4))
          0:       send_text("stop ");
          1:       send_text("sto");
          2:       send_text("Stop");
          default: send_text("stop");
        endcase
      end
      6: ;
      default: begin
        repeat ($urandom_range(1, 20)) send_byte(ByteW'($urandom));
      end
    endcase
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(($urandom_range(0, 1) != 0) ? ChBs : ChDel);
    end
    send_byte(($urandom_range(0, 1) != 0) ? ChCr : ChLf);
  endtask

  task automatic test_random_lines(input int item_goal);
    int start;
    start = result_count;
    while (result_count - start < item_goal) send_random_line();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_line_editing();
    test_full_line();
    test_min_above_max();

    // Default window, then several settings including the register extremes.
    configure(MinReset, MaxReset, StopReset, 1'b0);
    test_backpressure();
    test_random_lines(PhaseItems);

    configure(12'd0, 12'hFFF, 12'hFFF, 1'b0);
    test_random_lines(PhaseItems);

    configure(PulseW'($urandom_range(0, 2000)), PulseW'($urandom_range(2000, 4095)),
              PulseW'($urandom), 1'b1);
    test_random_lines(PhaseItems);

    configure(PulseW'($urandom_range(0, 100)), PulseW'($urandom_range(0, 200)),
              PulseW'($urandom), 1'b0);
    test_random_lines(PhaseItems);

    configure(PulseW'($urandom), PulseW'($urandom), PulseW'($urandom), 1'b1);
    test_random_lines(PhaseItems);

    // Drain: everything expected must arrive, then nothing more may appear.
    wait_idle();
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
